>>> src/pps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, field widths and controller/datapath handshake structs
// for the preemptive priority scheduler. No dependencies.
package pps_pkg;

   localparam int PPS_MAX_TASKS = 16;
   localparam int PPS_ID_W      = 8;
   localparam int PPS_LEFT_W    = 16;
   localparam int PPS_PRIO_W    = 8;
   localparam int PPS_ENTRY_W   = PPS_ID_W + PPS_LEFT_W + PPS_PRIO_W;

   // Command encoding of the request word
   localparam logic PPS_CMD_LOAD = 1'b0;
   localparam logic PPS_CMD_TICK = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // store the request word into the next free slot
      logic start;   // clear the best-so-far and rewind the scan counter
      logic issue;   // read the slot under the scan counter, advance it
      logic commit;  // write back the winner and load the result register
   } pps_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic empty;   // no slot loaded
      logic last;    // scan counter points at the last loaded slot
   } pps_sts_type;

endpackage

>>> src/preemptive_priority_scheduler_top.sv
`timescale 1ns / 1ps
// Preemptive priority scheduler, top level. A tick word rewinds the scan,
// reads the N loaded slots (one table RAM read per slot), compares the last
// slot, then commits the result; the next word is taken after the commit.
// A held result stalls only the next tick's commit.
// Synchronous reset empties the table and marks all slots done; the
// table RAM itself is not cleared. Depends on pps_pkg, pps_ctrl, pps_dp.
module preemptive_priority_scheduler_top import pps_pkg::*; #(
   parameter int MAX_TASKS = PPS_MAX_TASKS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [PPS_ID_W-1:0]   req_task_id,
   input  logic [PPS_LEFT_W-1:0] req_burst_length,
   input  logic [PPS_PRIO_W-1:0] req_task_priority,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PPS_ID_W-1:0]   rsp_run_id,
   output logic [PPS_LEFT_W-1:0] rsp_left_after,
   output logic                  rsp_finished,
   output logic                  rsp_idle
);

   pps_cmd_type cmd;
   pps_sts_type sts;

   pps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   pps_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_task_id       (req_task_id),
      .req_burst_length  (req_burst_length),
      .req_task_priority (req_task_priority),
      .rsp_run_id        (rsp_run_id),
      .rsp_left_after    (rsp_left_after),
      .rsp_finished      (rsp_finished),
      .rsp_idle          (rsp_idle)
   );

`ifndef NO_ASSERTIONS
   // Idle results carry all-zero fields
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_idle) |->
         (rsp_run_id == '0 && rsp_left_after == '0 && !rsp_finished))
      else $error("idle result with nonzero fields");

   // A finished task has no time left
   a_fin_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (rsp_left_after == '0 && !rsp_idle))
      else $error("finished result with time left");

   // Loads only on an accepted load word
   a_load_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && req_ready && req_command == PPS_CMD_LOAD))
      else $error("table load without an accepted load word");

   // A commit always presents a result next cycle
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without a result");
`endif

endmodule

>>> src/pps_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pps_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the scheduler: accepts request words, steps the slot scan
// and hands results to the output register. Depends on pps_pkg.
module pps_ctrl import pps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_command,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  pps_sts_type sts,
   output pps_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // Output register may be refilled when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == PPS_CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = sts.empty ? S_COMMIT : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            // last slot is compared in this cycle
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (slot_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/pps_dp.sv
`timescale 1ns / 1ps
// Scheduler datapath: task table RAM, done flags, entry count, running
// minimum search and the result register. Depends on pps_pkg and pps_ram.
module pps_dp import pps_pkg::*; #(
   parameter int MAX_TASKS = PPS_MAX_TASKS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pps_cmd_type           cmd,
   output pps_sts_type           sts,
   input  logic [PPS_ID_W-1:0]   req_task_id,
   input  logic [PPS_LEFT_W-1:0] req_burst_length,
   input  logic [PPS_PRIO_W-1:0] req_task_priority,
   output logic [PPS_ID_W-1:0]   rsp_run_id,
   output logic [PPS_LEFT_W-1:0] rsp_left_after,
   output logic                  rsp_finished,
   output logic                  rsp_idle
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);

   logic [CW-1:0]          count_ff;
   logic [MAX_TASKS-1:0]   done_ff;
   logic [IW-1:0]          scan_ff;
   logic                   chk_ff;
   logic [IW-1:0]          chk_idx_ff;
   logic                   found_ff;
   logic [IW-1:0]          best_idx_ff;
   logic [PPS_ID_W-1:0]    best_id_ff;
   logic [PPS_LEFT_W-1:0]  best_left_ff;
   logic [PPS_PRIO_W-1:0]  best_prio_ff;
   logic [PPS_ID_W-1:0]    run_id_ff;
   logic [PPS_LEFT_W-1:0]  left_after_ff;
   logic                   finished_ff;
   logic                   idle_ff;

   logic                   full;
   logic                   store;
   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   logic [PPS_ENTRY_W-1:0] wr_data;
   logic [PPS_ENTRY_W-1:0] rd_data;
   logic [PPS_ID_W-1:0]    rd_id;
   logic [PPS_LEFT_W-1:0]  rd_left;
   logic [PPS_PRIO_W-1:0]  rd_prio;
   logic                   take;
   logic [PPS_LEFT_W-1:0]  left_dec;
   logic                   fin;

   // Status toward the controller
   assign full      = (count_ff == CW'(MAX_TASKS));
   assign sts.empty = (count_ff == '0);
   assign sts.last  = ((CW'(scan_ff) + CW'(1)) == count_ff);
   assign store     = cmd.load && !full;

   // Decrement the winner, saturating at zero
   assign left_dec = (best_left_ff != '0) ? best_left_ff - PPS_LEFT_W'(1) : best_left_ff;
   assign fin      = (left_dec == '0);

   // Table port: loads append, commits write the winner back
   always_comb begin
      if (cmd.commit) begin
         wr_en   = found_ff;
         wr_addr = best_idx_ff;
         wr_data = {best_id_ff, left_dec, best_prio_ff};
      end else begin
         wr_en   = store;
         wr_addr = count_ff[IW-1:0];
         wr_data = {req_task_id, req_burst_length, req_task_priority};
      end
   end

   pps_ram #(
      .WIDTH (PPS_ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   assign {rd_id, rd_left, rd_prio} = rd_data;

   // Compare the slot read last cycle against the best so far
   assign take = chk_ff && !done_ff[chk_idx_ff] && (!found_ff || (rd_prio < best_prio_ff));

   // Control state: count, done flags, scan counter, search flags
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= '1;
         scan_ff  <= '0;
         chk_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         chk_ff <= cmd.issue;
         if (store) begin
            count_ff                    <= count_ff + CW'(1);
            done_ff[count_ff[IW-1:0]]   <= (req_burst_length == '0);
         end
         if (cmd.commit && found_ff && fin) begin
            done_ff[best_idx_ff] <= 1'b1;
         end
         if (cmd.start) begin
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.issue) begin
               scan_ff <= scan_ff + IW'(1);
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   // Best-so-far payload and the slot index tracking the read pipeline
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         chk_idx_ff <= scan_ff;
      end
      if (take) begin
         best_idx_ff  <= chk_idx_ff;
         best_id_ff   <= rd_id;
         best_left_ff <= rd_left;
         best_prio_ff <= rd_prio;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (found_ff) begin
            run_id_ff     <= best_id_ff;
            left_after_ff <= left_dec;
            finished_ff   <= fin;
            idle_ff       <= 1'b0;
         end else begin
            run_id_ff     <= '0;
            left_after_ff <= '0;
            finished_ff   <= 1'b0;
            idle_ff       <= 1'b1;
         end
      end
   end

   assign rsp_run_id     = run_id_ff;
   assign rsp_left_after = left_after_ff;
   assign rsp_finished   = finished_ff;
   assign rsp_idle       = idle_ff;

endmodule
